// ===== sv/rc5_pkg.sv =====
// rc5 shared types, constants and rotate helpers
package rc5_pkg;

	localparam logic [31:0] MAGIC_P = 32'hB7E15163;
	localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

	// apb side: 64-bit data, registers at 8-byte spacing
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	// half-index into the round key banks, covers up to 255 rounds
	localparam int HALF_W = 8;
	typedef logic [HALF_W-1:0] half_addr_t;
	typedef logic [2:0] kword_idx_t;

	typedef enum logic [1:0] {
		MODE_CBC_ENC = 2'd0,
		MODE_CBC_DEC = 2'd1,
		MODE_ECB_ENC = 2'd2,
		MODE_ECB_DEC = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_IV   = 3'd4,
		REG_MODE = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_KEYLOAD,
		OP_EXP_A,
		OP_EXP_B,
		OP_READ,
		OP_WHITEN,
		OP_ROUND
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		half_addr_t addr;
		logic       par;
		kword_idx_t jdx;
		logic       first;
		logic       load_item;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      iv;
		mode_t            mode;
	} cfg_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} >> n;
		return t[31:0];
	endfunction

endpackage

// ===== sv/rc5_if.sv =====
// rc5 block channels: input blocks and result blocks
interface rc5_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_a;
	logic [31:0] block_b;
	logic        start_of_message;

	modport source (output valid, output block_a, output block_b, output start_of_message,
		input ready);
	modport sink (input valid, input block_a, input block_b, input start_of_message,
		output ready);
endinterface

interface rc5_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_a;
	logic [31:0] out_b;

	modport source (output valid, output out_a, output out_b, input ready);
	modport sink (input valid, input out_a, input out_b, output ready);
endinterface

// ===== sv/rc5_block_cipher_cbc.sv =====
// rc5-32 block cipher top level with cbc and ecb modes
//
//  channel   | dir  | payload                                  | handshake
//  req       | in   | block_a, block_b, start_of_message       | valid / ready
//  rsp       | out  | out_a, out_b                             | valid / ready
//  apb       | in   | paddr, pwdata, prdata (64-bit registers)  | psel / penable, pready = 1
//
// an item is processed from accept to the next accept in key read, whitening, the rounds
// and result load, with one full round per cycle in the round unit. the first item after
// a key write first runs key mixing: a key load, then steps of an EXP_A and an EXP_B
// state each on the round key memory port.
// reset clears controller state, the chain value and the apb registers; the schedule is
// rebuilt on the first item. a new item is taken while a result waits in the output
// register; a stalled result only holds the block once the next result is ready.
module rc5_block_cipher_cbc import rc5_pkg::*; #(
	parameter int ROUNDS  = 20,
	parameter int KEY_LEN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	rc5_in_if.sink            req,
	rc5_out_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	logic    key_wr;
	dp_cmd_t cmd;

	assign pready = 1'b1;

	rc5_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.key_wr  (key_wr)
	);

	rc5_ctrl #(.ROUNDS(ROUNDS), .KEY_LEN(KEY_LEN)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.mode      (cfg.mode),
		.key_wr    (key_wr),
		.cmd       (cmd)
	);

	rc5_dp #(.ROUNDS(ROUNDS), .KEY_LEN(KEY_LEN)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg              (cfg),
		.block_a          (req.block_a),
		.block_b          (req.block_b),
		.start_of_message (req.start_of_message),
		.out_a            (rsp.out_a),
		.out_b            (rsp.out_b)
	);

	// taking an item means the datapath is not busy
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> cmd.op == OP_IDLE)
		else $error("input ready while datapath busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("ready stayed high after an accepted item");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !rsp.valid || rsp.ready)
		else $error("result register overwritten while stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp.valid)
		else $error("loaded result not presented");

endmodule

// ===== sv/rc5_ram.sv =====
// generic single-port ram with registered read
module rc5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/rc5_regs.sv =====
// rc5 apb register file: key words, iv and mode
module rc5_regs import rc5_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output cfg_t              cfg,
	output logic              key_wr
);

	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx = paddr[APB_AW-1:3];
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;
	assign key_wr = wr && (idx == REG_KEY0 || idx == REG_KEY1 ||
		idx == REG_KEY2 || idx == REG_KEY3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key  <= '0;
			cfg_q.iv   <= '0;
			cfg_q.mode <= MODE_CBC_ENC;
		end else if (wr) begin
			unique case (idx)
				REG_KEY0: cfg_q.key[0] <= pwdata;
				REG_KEY1: cfg_q.key[1] <= pwdata;
				REG_KEY2: cfg_q.key[2] <= pwdata;
				REG_KEY3: cfg_q.key[3] <= pwdata;
				REG_IV:   cfg_q.iv     <= pwdata;
				REG_MODE: cfg_q.mode   <= mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY0: prdata = cfg_q.key[0];
			REG_KEY1: prdata = cfg_q.key[1];
			REG_KEY2: prdata = cfg_q.key[2];
			REG_KEY3: prdata = cfg_q.key[3];
			REG_IV:   prdata = cfg_q.iv;
			REG_MODE: prdata = APB_DW'(cfg_q.mode);
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== sv/rc5_ctrl.sv =====
// rc5 controller: key expansion sequencing, round counting, handshakes
module rc5_ctrl import rc5_pkg::*; #(
	parameter int ROUNDS  = 20,
	parameter int KEY_LEN = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  logic    rsp_ready,
	output logic    rsp_valid,
	input  mode_t   mode,
	input  logic    key_wr,
	output dp_cmd_t cmd
);

	localparam int RK     = 2 * (ROUNDS + 1);
	localparam int KWORDS = (KEY_LEN + 3) / 4;
	localparam int TOTAL  = 3 * ((RK > KWORDS) ? RK : KWORDS);
	localparam int IW     = $clog2(RK);
	localparam int KCW    = $clog2(TOTAL);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KLOAD,
		ST_EXP_A,
		ST_EXP_B,
		ST_PRIME,
		ST_WHITEN,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t     state_q;
	dp_op_t     op_q;
	half_addr_t addr_q;
	half_addr_t r_q;
	logic       ready_q;
	logic       valid_q;
	logic       sched_q;
	logic [IW-1:0]  i_q;
	kword_idx_t     j_q;
	logic [KCW-1:0] k_q;

	logic [IW-1:0] i_nx;
	kword_idx_t    j_nx;
	logic          dec;
	logic          load_item;
	logic          load_out;
	half_addr_t    rlast;
	half_addr_t    h_nx;

	assign dec   = (mode == MODE_CBC_DEC) || (mode == MODE_ECB_DEC);
	assign rlast = half_addr_t'(ROUNDS);
	assign i_nx  = (i_q == IW'(RK - 1)) ? '0 : i_q + 1'b1;
	assign j_nx  = (j_q == kword_idx_t'(KWORDS - 1)) ? '0 : j_q + 1'b1;
	assign h_nx  = half_addr_t'(i_nx >> 1);

	assign load_item = req_valid && ready_q;
	assign load_out  = (state_q == ST_DONE) && (!valid_q || rsp_ready);

	assign req_ready = ready_q;
	assign rsp_valid = valid_q;

	assign cmd = '{
		op:        op_q,
		addr:      addr_q,
		par:       i_q[0],
		jdx:       j_q,
		first:     (k_q < KCW'(RK)),
		load_item: load_item,
		load_out:  load_out
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_IDLE;
			addr_q  <= '0;
			r_q     <= '0;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
			sched_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			if (key_wr) begin
				sched_q <= 1'b0;
			end
			if (load_out) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (load_item) begin
						ready_q <= 1'b0;
						if (!sched_q) begin
							state_q <= ST_KLOAD;
							op_q    <= OP_KEYLOAD;
						end else begin
							state_q <= ST_PRIME;
							op_q    <= OP_READ;
							addr_q  <= dec ? rlast : '0;
						end
					end
				end
				ST_KLOAD: begin
					i_q     <= '0;
					j_q     <= '0;
					k_q     <= '0;
					state_q <= ST_EXP_A;
					op_q    <= OP_EXP_A;
					addr_q  <= '0;
				end
				ST_EXP_A: begin
					// prefetch the next key slot while b is mixed
					state_q <= ST_EXP_B;
					op_q    <= OP_EXP_B;
					addr_q  <= h_nx;
				end
				ST_EXP_B: begin
					i_q <= i_nx;
					j_q <= j_nx;
					k_q <= k_q + 1'b1;
					if (k_q == KCW'(TOTAL - 1)) begin
						sched_q <= 1'b1;
						state_q <= ST_PRIME;
						op_q    <= OP_READ;
						addr_q  <= dec ? rlast : '0;
					end else begin
						state_q <= ST_EXP_A;
						op_q    <= OP_EXP_A;
						addr_q  <= h_nx;
					end
				end
				ST_PRIME: begin
					if (dec) begin
						state_q <= ST_ROUND;
						op_q    <= OP_ROUND;
						r_q     <= rlast;
						addr_q  <= rlast - 1'b1;
					end else begin
						state_q <= ST_WHITEN;
						op_q    <= OP_WHITEN;
						addr_q  <= half_addr_t'(1);
					end
				end
				ST_WHITEN: begin
					if (dec) begin
						state_q <= ST_DONE;
						op_q    <= OP_IDLE;
					end else begin
						state_q <= ST_ROUND;
						op_q    <= OP_ROUND;
						r_q     <= half_addr_t'(1);
						addr_q  <= (rlast > half_addr_t'(1)) ? half_addr_t'(2) : half_addr_t'(1);
					end
				end
				ST_ROUND: begin
					if (dec) begin
						// key pair 0 is already being read for the final whitening
						if (r_q == half_addr_t'(1)) begin
							state_q <= ST_WHITEN;
							op_q    <= OP_WHITEN;
						end else begin
							r_q    <= r_q - 1'b1;
							addr_q <= r_q - half_addr_t'(2);
						end
					end else begin
						if (r_q == rlast) begin
							state_q <= ST_DONE;
							op_q    <= OP_IDLE;
						end else begin
							r_q    <= r_q + 1'b1;
							addr_q <= (r_q + half_addr_t'(1) < rlast) ?
								r_q + half_addr_t'(2) : r_q + half_addr_t'(1);
						end
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= OP_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== sv/rc5_dp.sv =====
// rc5 datapath: key mixing, round unit, chaining and result register
module rc5_dp import rc5_pkg::*; #(
	parameter int ROUNDS  = 20,
	parameter int KEY_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  cfg_t        cfg,
	input  logic [31:0] block_a,
	input  logic [31:0] block_b,
	input  logic        start_of_message,
	output logic [31:0] out_a,
	output logic [31:0] out_b
);

	localparam int DEPTH = ROUNDS + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0] a_q, b_q;
	logic [31:0] ka_q, kb_q;
	logic [31:0] magic_q;
	logic [31:0] l_q [8];
	logic [63:0] ct_q;
	logic [63:0] chain_q;
	logic [31:0] out_a_q, out_b_q;

	logic [31:0] l_init [8];
	logic [31:0] rd_even, rd_odd;
	logic [31:0] src, ka_nx, kab, kb_nx;
	logic [31:0] ea, eb, da, db;
	logic [63:0] chain_eff;
	logic        dec;
	logic        we_even, we_odd;

	assign dec = (cfg.mode == MODE_CBC_DEC) || (cfg.mode == MODE_ECB_DEC);

	// even round keys in one bank, odd in the other, so a round reads both at once
	assign we_even = (cmd.op == OP_EXP_A) && !cmd.par;
	assign we_odd  = (cmd.op == OP_EXP_A) && cmd.par;

	rc5_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_even (
		.clk   (clk),
		.we    (we_even),
		.addr  (cmd.addr[AW-1:0]),
		.wdata (ka_nx),
		.rdata (rd_even)
	);

	rc5_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_odd (
		.clk   (clk),
		.we    (we_odd),
		.addr  (cmd.addr[AW-1:0]),
		.wdata (ka_nx),
		.rdata (rd_odd)
	);

	// key bytes packed little-endian into words, unused bytes zero
	always_comb begin
		int p;
		p = 0;
		for (int w = 0; w < 8; w++) begin
			for (int q = 0; q < 4; q++) begin
				p = 4 * w + q;
				l_init[w][8*q +: 8] = (p < KEY_LEN) ?
					cfg.key[p >> 3][8*(p & 7) +: 8] : 8'h00;
			end
		end
	end

	// first pass over the table uses the arithmetic-progression seed
	assign src   = cmd.first ? magic_q : (cmd.par ? rd_odd : rd_even);
	assign ka_nx = rotl32(src + ka_q + kb_q, 5'd3);
	assign kab   = ka_q + kb_q;
	assign kb_nx = rotl32(l_q[cmd.jdx] + kab, kab[4:0]);

	assign ea = rotl32(a_q ^ b_q, b_q[4:0]) + rd_even;
	assign eb = rotl32(b_q ^ ea, ea[4:0]) + rd_odd;
	assign db = rotr32(b_q - rd_odd, a_q[4:0]) ^ a_q;
	assign da = rotr32(a_q - rd_even, db[4:0]) ^ db;

	assign chain_eff = start_of_message ? cfg.iv : chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (cmd.load_item) begin
			chain_q <= chain_eff;
		end else if (cmd.load_out) begin
			if (cfg.mode == MODE_CBC_ENC) begin
				chain_q <= {b_q, a_q};
			end else if (cfg.mode == MODE_CBC_DEC) begin
				chain_q <= ct_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ct_q <= {block_b, block_a};
			if (cfg.mode == MODE_CBC_ENC) begin
				a_q <= block_a ^ chain_eff[31:0];
				b_q <= block_b ^ chain_eff[63:32];
			end else begin
				a_q <= block_a;
				b_q <= block_b;
			end
		end
		case (cmd.op)
			OP_KEYLOAD: begin
				l_q     <= l_init;
				ka_q    <= '0;
				kb_q    <= '0;
				magic_q <= MAGIC_P;
			end
			OP_EXP_A: begin
				ka_q <= ka_nx;
			end
			OP_EXP_B: begin
				kb_q           <= kb_nx;
				l_q[cmd.jdx]   <= kb_nx;
				magic_q        <= magic_q + MAGIC_Q;
			end
			OP_WHITEN: begin
				if (dec) begin
					if (cfg.mode == MODE_CBC_DEC) begin
						a_q <= (a_q - rd_even) ^ chain_q[31:0];
						b_q <= (b_q - rd_odd) ^ chain_q[63:32];
					end else begin
						a_q <= a_q - rd_even;
						b_q <= b_q - rd_odd;
					end
				end else begin
					a_q <= a_q + rd_even;
					b_q <= b_q + rd_odd;
				end
			end
			OP_ROUND: begin
				if (dec) begin
					a_q <= da;
					b_q <= db;
				end else begin
					a_q <= ea;
					b_q <= eb;
				end
			end
			default: ;
		endcase
		if (cmd.load_out) begin
			out_a_q <= a_q;
			out_b_q <= b_q;
		end
	end

	assign out_a = out_a_q;
	assign out_b = out_b_q;

endmodule
